@@ hdl/rnps_pkg.sv @@
// Shared types and constants for the relative nearest point search core.
// No dependencies; imported by relative_nearest_point_search_core.
package rnps_pkg;

    localparam int COORD_W = 24;   // signed Q15.8 coordinates
    localparam int TRK_W   = 4;
    localparam int PNT_W   = 13;
    localparam int RATIO_W = 16;   // unsigned Q0.16
    localparam int CFG_IDX_W = 2;

    // Shared multiplier: 25x25 unsigned magnitudes
    localparam int MUL_W  = COORD_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int HALF_W = MUL_W;

    // |P-Q|^2 < 3*2^48, |P|^2 <= 3*2^46
    localparam int D2_W  = 50;
    localparam int N2_W  = 48;
    // signed difference of the two cross products, each < 2^98
    localparam int ACC_W = 99;

    localparam logic [TRK_W-1:0]   TRK_MAX   = TRK_W'(10);
    localparam logic [PNT_W-1:0]   PNT_MAX   = PNT_W'(4096);
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(6554);
    localparam logic [N2_W-1:0]    NORM_ONE  = N2_W'(64'h1_0000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QX    = 2'd0,
        CFG_QY    = 2'd1,
        CFG_QZ    = 2'd2,
        CFG_RATIO = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    // Multiplier schedule, one product per step
    typedef enum logic [3:0] {
        STP_RATIO,  // start_ratio^2
        STP_DX, STP_DY, STP_DZ,   // |P-Q|^2 terms
        STP_NX, STP_NY, STP_NZ,   // |P|^2 terms
        STP_L00, STP_L01, STP_L10, STP_L11,  // d2 * best_norm
        STP_R00, STP_R01, STP_R10, STP_R11,  // best_dist * n2
        STP_FLUSH   // last product drains into the accumulator
    } t_step;

endpackage

@@ hdl/relative_nearest_point_search_core.sv @@
// Relative nearest point search core: one shared multiplier under a step sequencer.
// Depends on rnps_pkg (types, widths, schedule codes).
//
//  channel | beat signals                  | payload
//  --------+-------------------------------+---------------------------------------------
//  cfg     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//  in      | i_in_valid  / o_in_ready      | i_point_x/y/z, i_track_number,
//          |                               | i_point_number, i_last_point
//  out     | o_out_valid / i_out_ready     | o_found, o_best_track, o_best_point
//
// Each input beat is captured, then passes through 16 sequencer steps on the
// single 25x25 multiplier (one pipeline register behind it) and a decide state.
// o_in_ready is high only while idle. Config is always ready.
// A last-point beat produces one output beat; the output register lets the core
// take new input while a result waits. If the previous result is still unclaimed
// when another last point finishes, the core holds in the decide cycle.
// Reset (synchronous, active low) restores the query to the origin, the ratio to
// 0.1 and clears the running best; there is no clearing pass.
module relative_nearest_point_search_core
    import rnps_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COORD_W-1:0]        i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [TRK_W-1:0]          i_track_number,
    input  logic [PNT_W-1:0]          i_point_number,
    input  logic                      i_last_point,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_found,
    output logic [TRK_W-1:0]          o_best_track,
    output logic [PNT_W-1:0]          o_best_point
);

    // magnitude of a 25-bit signed value; -2^24 maps to 2^24 unsigned
    function automatic logic [MUL_W-1:0] mag(input logic signed [MUL_W-1:0] v);
        logic [MUL_W-1:0] r;
        r = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
        return r;
    endfunction

    // configuration registers
    logic signed [COORD_W-1:0] r_qx, r_qy, r_qz;
    logic [RATIO_W-1:0]        r_ratio;

    // sequencer
    t_state r_state, n_state;
    t_step  r_step, r_pstep;

    // captured beat
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [TRK_W-1:0]          r_trk;
    logic [PNT_W-1:0]          r_pnt;
    logic                      r_last;

    // datapath
    logic [PROD_W-1:0]         r_prod;
    logic [D2_W-1:0]           r_d2;
    logic [N2_W-1:0]           r_n2;
    logic [ACC_W-1:0]          r_acc;

    // running best
    logic [D2_W-1:0]           r_bd;
    logic [N2_W-1:0]           r_bn;
    logic                      r_chosen;
    logic [TRK_W-1:0]          r_best_trk;
    logic [PNT_W-1:0]          r_best_pnt;

    // output register
    logic                      r_out_valid;
    logic                      r_found;
    logic [TRK_W-1:0]          r_out_trk;
    logic [PNT_W-1:0]          r_out_pnt;

    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [ACC_W-1:0]          prod_ext;
    logic                      in_beat, tag_ok, taken, out_free, finish;

    assign in_beat  = i_in_valid && o_in_ready;
    assign tag_ok   = (r_trk != '0) && (r_trk <= TRK_MAX) &&
                      (r_pnt != '0) && (r_pnt <= PNT_MAX);
    // negative accumulator: |P-Q|^2 * best_norm < best_dist * |P|^2
    assign taken    = tag_ok && r_acc[ACC_W-1];
    assign out_free = !r_out_valid || i_out_ready;
    assign finish   = (r_state == ST_DONE) && (!r_last || out_free);
    assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, r_prod};

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_best_track = r_out_trk;
    assign o_best_point = r_out_pnt;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_step)
            STP_RATIO: begin
                mul_a = MUL_W'(r_ratio);
                mul_b = MUL_W'(r_ratio);
            end
            STP_DX: begin
                mul_a = mag(MUL_W'({r_px[COORD_W-1], r_px}) - MUL_W'({r_qx[COORD_W-1], r_qx}));
                mul_b = mul_a;
            end
            STP_DY: begin
                mul_a = mag(MUL_W'({r_py[COORD_W-1], r_py}) - MUL_W'({r_qy[COORD_W-1], r_qy}));
                mul_b = mul_a;
            end
            STP_DZ: begin
                mul_a = mag(MUL_W'({r_pz[COORD_W-1], r_pz}) - MUL_W'({r_qz[COORD_W-1], r_qz}));
                mul_b = mul_a;
            end
            STP_NX: begin
                mul_a = mag({r_px[COORD_W-1], r_px});
                mul_b = mul_a;
            end
            STP_NY: begin
                mul_a = mag({r_py[COORD_W-1], r_py});
                mul_b = mul_a;
            end
            STP_NZ: begin
                mul_a = mag({r_pz[COORD_W-1], r_pz});
                mul_b = mul_a;
            end
            STP_L00: begin
                mul_a = r_d2[HALF_W-1:0];
                mul_b = r_bn[HALF_W-1:0];
            end
            STP_L01: begin
                mul_a = r_d2[HALF_W-1:0];
                mul_b = MUL_W'(r_bn[N2_W-1:HALF_W]);
            end
            STP_L10: begin
                mul_a = r_d2[D2_W-1:HALF_W];
                mul_b = r_bn[HALF_W-1:0];
            end
            STP_L11: begin
                mul_a = r_d2[D2_W-1:HALF_W];
                mul_b = MUL_W'(r_bn[N2_W-1:HALF_W]);
            end
            STP_R00: begin
                mul_a = r_bd[HALF_W-1:0];
                mul_b = r_n2[HALF_W-1:0];
            end
            STP_R01: begin
                mul_a = r_bd[HALF_W-1:0];
                mul_b = MUL_W'(r_n2[N2_W-1:HALF_W]);
            end
            STP_R10: begin
                mul_a = r_bd[D2_W-1:HALF_W];
                mul_b = r_n2[HALF_W-1:0];
            end
            STP_R11: begin
                mul_a = r_bd[D2_W-1:HALF_W];
                mul_b = MUL_W'(r_n2[N2_W-1:HALF_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_step == STP_FLUSH) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx    <= '0;
            r_qy    <= '0;
            r_qz    <= '0;
            r_ratio <= RATIO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_QX:    r_qx    <= i_cfg_data;
                CFG_QY:    r_qy    <= i_cfg_data;
                CFG_QZ:    r_qz    <= i_cfg_data;
                CFG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                default:   ;
            endcase
        end
    end

    // capture and multiply/accumulate datapath
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
            r_trk  <= i_track_number;
            r_pnt  <= i_point_number;
            r_last <= i_last_point;
            r_step <= STP_RATIO;
        end
        if (r_state == ST_CALC) begin
            r_prod  <= mul_a * mul_b;
            r_pstep <= r_step;
            r_step  <= t_step'(r_step + 1'b1);
            // product issued last step lands here
            if (r_step != STP_RATIO) begin
                case (r_pstep) inside
                    STP_DX:  r_d2  <= D2_W'(r_prod);
                    STP_DY,
                    STP_DZ:  r_d2  <= r_d2 + D2_W'(r_prod);
                    STP_NX:  r_n2  <= N2_W'(r_prod);
                    STP_NY,
                    STP_NZ:  r_n2  <= r_n2 + N2_W'(r_prod);
                    STP_L00: r_acc <= prod_ext;
                    STP_L01,
                    STP_L10: r_acc <= r_acc + (prod_ext << HALF_W);
                    STP_L11: r_acc <= r_acc + (prod_ext << (2 * HALF_W));
                    STP_R00: r_acc <= r_acc - prod_ext;
                    STP_R01,
                    STP_R10: r_acc <= r_acc - (prod_ext << HALF_W);
                    STP_R11: r_acc <= r_acc - (prod_ext << (2 * HALF_W));
                    default: ;
                endcase
            end
        end
    end

    // running best and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen    <= 1'b0;
            r_best_trk  <= '0;
            r_best_pnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // bound reloads from the current ratio until a point is chosen
            if (r_state == ST_CALC && !r_chosen) begin
                if (r_step == STP_RATIO) begin
                    r_bn <= NORM_ONE;
                end
                if (r_step == STP_DX) begin
                    r_bd <= D2_W'(r_prod);
                end
            end
            if (finish) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_found     <= taken || r_chosen;
                    r_out_trk   <= taken ? r_trk : r_best_trk;
                    r_out_pnt   <= taken ? r_pnt : r_best_pnt;
                    r_chosen    <= 1'b0;
                    r_best_trk  <= '0;
                    r_best_pnt  <= '0;
                end else if (taken) begin
                    r_bd       <= r_d2;
                    r_bn       <= r_n2;
                    r_chosen   <= 1'b1;
                    r_best_trk <= r_trk;
                    r_best_pnt <= r_pnt;
                end
            end
        end
    end

endmodule
